[hdl/bee_pkg.sv]
// ----------------------------------------------------------------------------
// bee_pkg
// Shared types, character codes and helpers for the boolean expression
// evaluator.
// ----------------------------------------------------------------------------
package bee_pkg;

    // Frame stack depth and the widths that follow from it.
    localparam int MAX_DEPTH = 32;
    localparam int CNT_W     = $clog2(MAX_DEPTH + 1);
    localparam int ADDR_W    = $clog2(MAX_DEPTH);

    // ASCII characters that the evaluator reacts to.
    localparam logic [7:0] CH_AND = 8'h26;  // '&'
    localparam logic [7:0] CH_OR  = 8'h7C;  // '|'
    localparam logic [7:0] CH_NOT = 8'h21;  // '!'
    localparam logic [7:0] CH_T   = 8'h74;  // 't'
    localparam logic [7:0] CH_F   = 8'h66;  // 'f'
    localparam logic [7:0] CH_RP  = 8'h29;  // ')'

    // Operator held in a frame.
    typedef enum logic [1:0] {
        OP_AND = 2'd0,
        OP_OR  = 2'd1,
        OP_NOT = 2'd2
    } op_t;

    // One frame of the operator stack.
    typedef struct packed {
        op_t  op;
        logic val;
    } frame_t;

    // One finished result.
    typedef struct packed {
        logic overflow;
        logic value;
    } result_t;

    // Fold one operand bit into a running value.
    function automatic logic combine(op_t op, logic acc, logic b);
        logic r;
        case (op)
            OP_AND:  r = acc & b;
            OP_OR:   r = acc | b;
            default: r = b;
        endcase
        return r;
    endfunction

endpackage

[hdl/bee_core.sv]
// ----------------------------------------------------------------------------
// bee_core
// Frame stack engine: the top frame lives in a register, the frames below it
// in a synchronous memory; the frame under the top is prefetched every cycle.
// ----------------------------------------------------------------------------
module bee_core
    import bee_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_fire,
    input  logic [7:0] symbol,
    input  logic       last_symbol,
    output logic       res_valid,
    output result_t    res
);

    // Frame memory: entry i holds frame i for every frame below the top.
    frame_t mem [MAX_DEPTH];

    logic [CNT_W-1:0]  count_reg, count_next;
    frame_t            top_reg, top_next;
    logic              tlv_reg, tlv_next;
    logic              ovf_reg, ovf_next;
    logic              ovf_seen;
    logic              tlv_final;

    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    frame_t            wr_data;
    logic [CNT_W-1:0]  rd_index;
    logic [ADDR_W-1:0] rd_addr;
    frame_t            rd_data_reg;
    logic              fwd_reg;
    frame_t            fwd_data_reg;
    frame_t            below;
    logic              popped;

    // The frame under the top: either fresh memory data or the bypassed write.
    assign below = fwd_reg ? fwd_data_reg : rd_data_reg;

    // Next state of the stack for the accepted character.
    always_comb
    begin
        count_next = count_reg;
        top_next   = top_reg;
        tlv_next   = tlv_reg;
        ovf_seen   = ovf_reg;
        wr_en      = 1'b0;
        wr_addr    = ADDR_W'(count_reg - CNT_W'(1));
        wr_data    = top_reg;
        popped     = top_reg.val ^ (top_reg.op == OP_NOT);
        res_valid  = 1'b0;
        res        = '0;
        tlv_final  = 1'b0;

        if (in_fire)
        begin
            case (symbol)
                CH_AND, CH_OR, CH_NOT:
                begin
                    if (count_reg == CNT_W'(MAX_DEPTH))
                    begin
                        ovf_seen = 1'b1;
                    end
                    else
                    begin
                        // Spill the current top below the new frame.
                        wr_en = (count_reg != '0);
                        if (symbol == CH_AND)
                        begin
                            top_next = '{op: OP_AND, val: 1'b1};
                        end
                        else if (symbol == CH_OR)
                        begin
                            top_next = '{op: OP_OR, val: 1'b0};
                        end
                        else
                        begin
                            top_next = '{op: OP_NOT, val: 1'b0};
                        end
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                CH_T, CH_F:
                begin
                    if (count_reg == '0)
                    begin
                        tlv_next = (symbol == CH_T);
                    end
                    else
                    begin
                        top_next.val = combine(top_reg.op, top_reg.val, symbol == CH_T);
                    end
                end
                CH_RP:
                begin
                    if (count_reg != '0)
                    begin
                        count_next = count_reg - CNT_W'(1);
                        if (count_reg == CNT_W'(1))
                        begin
                            tlv_next = popped;
                        end
                        else
                        begin
                            top_next.op  = below.op;
                            top_next.val = combine(below.op, below.val, popped);
                        end
                    end
                end
                default:
                begin
                end
            endcase

            // The last character delivers the result and clears the state.
            if (last_symbol)
            begin
                tlv_final    = tlv_next;
                res_valid    = 1'b1;
                res.overflow = ovf_seen;
                res.value    = ovf_seen ? 1'b0 : tlv_final;
                count_next   = '0;
                tlv_next     = 1'b0;
                ovf_seen     = 1'b0;
            end
        end
        ovf_next = ovf_seen;
    end

    // Prefetch the frame that will sit under the next top.
    assign rd_index = count_next - CNT_W'(2);
    assign rd_addr  = rd_index[ADDR_W-1:0];

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            tlv_reg   <= 1'b0;
            ovf_reg   <= 1'b0;
            fwd_reg   <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            tlv_reg   <= tlv_next;
            ovf_reg   <= ovf_next;
            fwd_reg   <= wr_en && (wr_addr == rd_addr);
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        top_reg      <= top_next;
        fwd_data_reg <= wr_data;
    end

    // Frame memory with registered read.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

endmodule

[hdl/boolean_expression_evaluator.sv]
// ----------------------------------------------------------------------------
// boolean_expression_evaluator
// Streaming evaluator of nested t/f expressions built from & | ! ( ) and ','.
// ----------------------------------------------------------------------------
// Usage:
//   Characters arrive on the s_axis channel, one word per character, with
//   s_axis_tlast marking the final character of an expression. A character
//   stream can run at one word per clock while s_axis_tready is high, since
//   each character does a single push, pop or fold on the frame stack. The
//   frame under the top is prefetched from the frame memory every cycle, and
//   a push is bypassed around that prefetch through a forwarding register.
//   The result word is registered for m_axis once the last character is
//   accepted: bit 0 is the value, bit 1 the overflow flag (value reads 0 when
//   overflow is set). Only the last character of an expression yields a word.
//   Results pass through an output register and a skid register, so input
//   keeps flowing while one result waits; s_axis_tready drops only while both
//   hold results the receiver has not taken.
//   Reset clears the stack count, the top-level value and the overflow flag;
//   no memory clear is needed, and the block accepts input right after reset.
//   After each result the evaluator starts afresh for the next expression.
// ----------------------------------------------------------------------------
module boolean_expression_evaluator
    import bee_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] symbol
    input  logic       s_axis_tlast,   // last_symbol
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata    // [0] value, [1] overflow, [7:2] zero
);

    logic    in_fire;
    logic    take;
    logic    res_valid;
    result_t res;
    logic    out_valid_reg;
    result_t out_data_reg;
    logic    skid_valid_reg;
    result_t skid_data_reg;

    assign s_axis_tready = !skid_valid_reg;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign take          = out_valid_reg && m_axis_tready;

    // Stack engine.
    bee_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_fire     (in_fire),
        .symbol      (s_axis_tdata),
        .last_symbol (s_axis_tlast),
        .res_valid   (res_valid),
        .res         (res)
    );

    // Output register with a skid stage behind it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            if (skid_valid_reg)
            begin
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= res_valid;
            end
        end
        else if (res_valid)
        begin
            if (!out_valid_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else
            begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    // Result payloads follow the same steering.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            if (skid_valid_reg)
            begin
                out_data_reg <= skid_data_reg;
            end
            else
            begin
                out_data_reg <= res;
            end
        end
        else if (res_valid)
        begin
            if (!out_valid_reg)
            begin
                out_data_reg <= res;
            end
            else
            begin
                skid_data_reg <= res;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'b0, out_data_reg.overflow, out_data_reg.value};

endmodule
